// File: design/lqm_pkg.sv
// ----------------------------------------------------------------------------
// lqm_pkg
// Shared types and constants for the link quality monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lqm_pkg;

  localparam int unsigned RTT_W  = 24;
  localparam int unsigned LOSS_W = 14;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_LOSS_EXC = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOSS_GD  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOSS_FR  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RTT_EXC  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RTT_GD   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RTT_FR   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_JIT_GD   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_JIT_FR   = 4'd7;

  localparam logic [1:0] MODE_SENT = 2'd0;
  localparam logic [1:0] MODE_RECV = 2'd1;
  localparam logic [1:0] MODE_RTT  = 2'd2;

  typedef enum logic [1:0] {
    DIV_RATE,
    DIV_MEAN,
    DIV_VAR
  } div_sel_e;

  typedef struct packed {
    logic     accept;
    logic     div_start;
    div_sel_e div_sel;
    logic     scan_clr;
    logic     scan_pass2;
    logic     scan_step;
    logic     sqrt_start;
    logic     out_load;
  } lqm_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic sqrt_busy;
    logic scan_last;
    logic fill_ge2;
  } lqm_sts_t;

endpackage

`default_nettype wire

// File: design/lqm_if.sv
// ----------------------------------------------------------------------------
// lqm_if
// Request channels of the link quality monitor: event in, metrics out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lqm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [23:0] rtt_sample;

  modport source (output valid, output mode, output rtt_sample, input ready);
  modport sink   (input valid, input mode, input rtt_sample, output ready);
endinterface

interface lqm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  quality;
  logic [13:0] loss_rate;
  logic [31:0] lost_count;
  logic [23:0] mean_rtt;
  logic [23:0] min_rtt;
  logic [23:0] max_rtt;
  logic [23:0] jitter;

  modport source (output valid, output quality, output loss_rate, output lost_count,
                  output mean_rtt, output min_rtt, output max_rtt, output jitter,
                  input ready);
  modport sink   (input valid, input quality, input loss_rate, input lost_count,
                  input mean_rtt, input min_rtt, input max_rtt, input jitter,
                  output ready);
endinterface

`default_nettype wire

// File: design/lqm_ctrl.sv
// ----------------------------------------------------------------------------
// lqm_ctrl
// Sequencer: counter update, loss divide; with two or more samples, two
// window scans, mean and variance divides and square root; result load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lqm_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  input  wire lqm_pkg::lqm_sts_t sts_i,
  output      lqm_pkg::lqm_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RATE   = 4'd1;
  localparam logic [3:0] S_RATE_W = 4'd2;
  localparam logic [3:0] S_SCAN1  = 4'd3;
  localparam logic [3:0] S_DRAIN1 = 4'd4;
  localparam logic [3:0] S_MEAN   = 4'd5;
  localparam logic [3:0] S_MEAN_W = 4'd6;
  localparam logic [3:0] S_SCAN2  = 4'd7;
  localparam logic [3:0] S_DRAIN2 = 4'd8;
  localparam logic [3:0] S_VAR    = 4'd9;
  localparam logic [3:0] S_VAR_W  = 4'd10;
  localparam logic [3:0] S_SQRT   = 4'd11;
  localparam logic [3:0] S_SQRT_W = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;

  logic [3:0] state_q, state_d;
  logic [1:0] drain_q, drain_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    drain_d = drain_q;
    cmd_o   = '0;
    cmd_o.div_sel = lqm_pkg::DIV_RATE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) state_d = S_RATE;
      end
      S_RATE: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = lqm_pkg::DIV_RATE;
        state_d = S_RATE_W;
      end
      S_RATE_W: begin
        if (!sts_i.div_busy) begin
          if (sts_i.fill_ge2) begin
            cmd_o.scan_clr = 1'b1;
            state_d = S_SCAN1;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_SCAN1: begin
        cmd_o.scan_step = 1'b1;
        drain_d = '0;
        if (sts_i.scan_last) state_d = S_DRAIN1;
      end
      S_DRAIN1: begin
        drain_d = drain_q + 2'd1;
        if (drain_q == 2'd2) state_d = S_MEAN;
      end
      S_MEAN: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = lqm_pkg::DIV_MEAN;
        state_d = S_MEAN_W;
      end
      S_MEAN_W: begin
        if (!sts_i.div_busy) begin
          cmd_o.scan_clr   = 1'b1;
          cmd_o.scan_pass2 = 1'b1;
          state_d = S_SCAN2;
        end
      end
      S_SCAN2: begin
        cmd_o.scan_step = 1'b1;
        drain_d = '0;
        if (sts_i.scan_last) state_d = S_DRAIN2;
      end
      S_DRAIN2: begin
        drain_d = drain_q + 2'd1;
        if (drain_q == 2'd2) state_d = S_VAR;
      end
      S_VAR: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = lqm_pkg::DIV_VAR;
        state_d = S_VAR_W;
      end
      S_VAR_W: begin
        if (!sts_i.div_busy) state_d = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_start = 1'b1;
        state_d = S_SQRT_W;
      end
      S_SQRT_W: begin
        if (!sts_i.sqrt_busy) state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      drain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      drain_q     <= drain_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten while pending");

  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.div_start, cmd_o.sqrt_start, cmd_o.scan_step, cmd_o.accept}))
    else $error("more than one unit started");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!sts_i.div_busy && !sts_i.sqrt_busy))
    else $error("unit busy while idle");

  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

// File: design/lqm_dp.sv
// ----------------------------------------------------------------------------
// lqm_dp
// Datapath: counters, sample window memory, scan pipeline, shared
// restoring divider, integer square root, grading and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lqm_dp #(
  parameter int unsigned WINDOW              = 64,
  parameter int unsigned JITTER_EXCELLENT_US = 2000
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire lqm_pkg::lqm_cmd_t                    cmd_i,
  output      lqm_pkg::lqm_sts_t                    sts_o,
  input  wire logic [1:0]                           mode_i,
  input  wire logic [lqm_pkg::RTT_W-1:0]            rtt_sample_i,
  input  wire logic                                 cfg_we_i,
  input  wire logic [lqm_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [lqm_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output      logic [1:0]                           quality_o,
  output      logic [lqm_pkg::LOSS_W-1:0]           loss_rate_o,
  output      logic [lqm_pkg::CNT_W-1:0]            lost_count_o,
  output      logic [lqm_pkg::RTT_W-1:0]            mean_rtt_o,
  output      logic [lqm_pkg::RTT_W-1:0]            min_rtt_o,
  output      logic [lqm_pkg::RTT_W-1:0]            max_rtt_o,
  output      logic [lqm_pkg::RTT_W-1:0]            jitter_o
);

  localparam int unsigned RW     = lqm_pkg::RTT_W;
  localparam int unsigned LW     = lqm_pkg::LOSS_W;
  localparam int unsigned CW     = lqm_pkg::CNT_W;
  localparam int unsigned AW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned FW     = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = RW + FW;
  localparam int unsigned SQ_W   = 2 * RW + FW;
  localparam int unsigned NW     = 2 * RW + FW;
  localparam int unsigned DCW    = $clog2(NW + 1);
  localparam int unsigned VW     = 2 * RW;
  localparam logic [CW-1:0] CNT_MAX = '1;
  localparam logic [LW-1:0] LOSS_SCALE = 14'd10000;

  // configuration
  logic [LW-1:0] loss_exc_q, loss_gd_q, loss_fr_q;
  logic [RW-1:0] rtt_exc_q, rtt_gd_q, rtt_fr_q, jit_gd_q, jit_fr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loss_exc_q <= 14'd100;
      loss_gd_q  <= 14'd300;
      loss_fr_q  <= 14'd1000;
      rtt_exc_q  <= 24'd20000;
      rtt_gd_q   <= 24'd50000;
      rtt_fr_q   <= 24'd100000;
      jit_gd_q   <= 24'd5000;
      jit_fr_q   <= 24'd10000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lqm_pkg::CFG_LOSS_EXC: loss_exc_q <= cfg_data_i[LW-1:0];
        lqm_pkg::CFG_LOSS_GD:  loss_gd_q  <= cfg_data_i[LW-1:0];
        lqm_pkg::CFG_LOSS_FR:  loss_fr_q  <= cfg_data_i[LW-1:0];
        lqm_pkg::CFG_RTT_EXC:  rtt_exc_q  <= cfg_data_i;
        lqm_pkg::CFG_RTT_GD:   rtt_gd_q   <= cfg_data_i;
        lqm_pkg::CFG_RTT_FR:   rtt_fr_q   <= cfg_data_i;
        lqm_pkg::CFG_JIT_GD:   jit_gd_q   <= cfg_data_i;
        lqm_pkg::CFG_JIT_FR:   jit_fr_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // counters and window
  logic [CW-1:0] sent_q, recv_q;
  logic [AW-1:0] head_q;
  logic [FW-1:0] fill_q;
  logic [RW-1:0] mem [WINDOW];
  logic [AW-1:0] idx_q;
  logic [RW-1:0] rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q <= '0;
      recv_q <= '0;
      head_q <= '0;
      fill_q <= '0;
    end else if (cmd_i.accept) begin
      case (mode_i)
        lqm_pkg::MODE_SENT: if (sent_q != CNT_MAX) sent_q <= sent_q + CW'(1);
        lqm_pkg::MODE_RECV: if (recv_q != CNT_MAX) recv_q <= recv_q + CW'(1);
        lqm_pkg::MODE_RTT: begin
          head_q <= (head_q == AW'(WINDOW - 1)) ? '0 : head_q + AW'(1);
          if (fill_q != FW'(WINDOW)) fill_q <= fill_q + FW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && mode_i == lqm_pkg::MODE_RTT) mem[head_q] <= rtt_sample_i;
    if (cmd_i.scan_step) rd_q <= mem[idx_q];
  end

  // scan pipeline
  logic          pass2_q, v1_q, v2_q, v3_q;
  logic [SUM_W-1:0] sum_q;
  logic [RW-1:0] min_q, max_q, d_q, mean_q;
  logic [VW-1:0] prod_q;
  logic [SQ_W-1:0] sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      pass2_q <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else begin
      if (cmd_i.scan_clr) begin
        idx_q   <= '0;
        pass2_q <= cmd_i.scan_pass2;
      end else if (cmd_i.scan_step) begin
        idx_q <= idx_q + AW'(1);
      end
      v1_q <= cmd_i.scan_step;
      v2_q <= v1_q && pass2_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_clr) begin
      if (!cmd_i.scan_pass2) begin
        sum_q <= '0;
        min_q <= '1;
        max_q <= '0;
      end else begin
        sq_q <= '0;
      end
    end else begin
      if (v1_q && !pass2_q) begin
        sum_q <= sum_q + SUM_W'(rd_q);
        if (rd_q < min_q) min_q <= rd_q;
        if (rd_q > max_q) max_q <= rd_q;
      end
      if (v3_q) sq_q <= sq_q + SQ_W'(prod_q);
    end
    if (v1_q && pass2_q) d_q <= (rd_q > mean_q) ? rd_q - mean_q : mean_q - rd_q;
    if (v2_q) prod_q <= VW'(d_q) * VW'(d_q);
  end

  // shared restoring divider
  logic            div_busy_q;
  logic [DCW-1:0]  div_cnt_q;
  lqm_pkg::div_sel_e div_sel_q;
  logic [NW-1:0]   num_q;
  logic [CW-1:0]   den_q, rem_q, lost_q;
  logic [LW-1:0]   rate_q;
  logic [VW-1:0]   var_q;
  logic [CW:0]     div_r;
  logic            div_ge;
  logic [CW-1:0]   lost_c;
  logic [NW-1:0]   num_c;
  logic [NW-1:0]   quot_c;

  assign lost_c = (sent_q > recv_q) ? sent_q - recv_q : '0;
  assign div_r  = {rem_q, num_q[NW-1]};
  assign div_ge = div_r >= {1'b0, den_q};
  assign quot_c = {num_q[NW-2:0], div_ge};

  always_comb begin
    case (cmd_i.div_sel)
      lqm_pkg::DIV_RATE: num_c = NW'(lost_c * LOSS_SCALE);
      lqm_pkg::DIV_MEAN: num_c = NW'(sum_q);
      lqm_pkg::DIV_VAR:  num_c = NW'(sq_q);
      default:           num_c = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= DCW'(NW);
    end else if (div_busy_q) begin
      div_cnt_q <= div_cnt_q - DCW'(1);
      if (div_cnt_q == DCW'(1)) div_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      div_sel_q <= cmd_i.div_sel;
      num_q     <= num_c;
      rem_q     <= '0;
      den_q     <= (cmd_i.div_sel == lqm_pkg::DIV_RATE) ? sent_q : CW'(fill_q);
      if (cmd_i.div_sel == lqm_pkg::DIV_RATE) lost_q <= lost_c;
    end else if (div_busy_q) begin
      num_q <= quot_c;
      rem_q <= div_ge ? CW'(div_r - {1'b0, den_q}) : CW'(div_r);
      if (div_cnt_q == DCW'(1)) begin
        case (div_sel_q)
          lqm_pkg::DIV_RATE: rate_q <= (den_q == '0) ? '0 : quot_c[LW-1:0];
          lqm_pkg::DIV_MEAN: mean_q <= quot_c[RW-1:0];
          lqm_pkg::DIV_VAR:  var_q  <= quot_c[VW-1:0];
          default: ;
        endcase
      end
    end
  end

  // integer square root, two bits a step
  logic            sqrt_busy_q;
  logic [4:0]      sqrt_cnt_q;
  logic [VW-1:0]   sv_q;
  logic [RW+1:0]   srem_q;
  logic [RW-1:0]   root_q;
  logic [RW+3:0]   s_r, s_t;
  logic            s_ge;

  assign s_r  = {srem_q, sv_q[VW-1:VW-2]};
  assign s_t  = {2'b00, root_q, 2'b01};
  assign s_ge = s_r >= s_t;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sqrt_busy_q <= 1'b0;
      sqrt_cnt_q  <= '0;
    end else if (cmd_i.sqrt_start) begin
      sqrt_busy_q <= 1'b1;
      sqrt_cnt_q  <= 5'(RW);
    end else if (sqrt_busy_q) begin
      sqrt_cnt_q <= sqrt_cnt_q - 5'd1;
      if (sqrt_cnt_q == 5'd1) sqrt_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      sv_q   <= var_q;
      srem_q <= '0;
      root_q <= '0;
    end else if (sqrt_busy_q) begin
      sv_q   <= {sv_q[VW-3:0], 2'b00};
      srem_q <= s_ge ? (RW+2)'(s_r - s_t) : (RW+2)'(s_r);
      root_q <= {root_q[RW-2:0], s_ge};
    end
  end

  // grading and result registers
  function automatic logic [1:0] grade(input logic [RW-1:0] v, input logic [RW-1:0] l1,
                                       input logic [RW-1:0] l2, input logic [RW-1:0] l3);
    logic [1:0] g;
    if (v > l3)      g = 2'd3;
    else if (v > l2) g = 2'd2;
    else if (v > l1) g = 2'd1;
    else             g = 2'd0;
    return g;
  endfunction

  logic          ge2;
  logic [RW-1:0] mean_c, jit_c;
  logic [1:0]    g_loss, g_rtt, g_jit, q_c;

  assign ge2    = fill_q >= FW'(2);
  assign mean_c = ge2 ? mean_q : '0;
  assign jit_c  = ge2 ? root_q : '0;
  assign g_loss = grade(RW'(rate_q), RW'(loss_exc_q), RW'(loss_gd_q), RW'(loss_fr_q));
  assign g_rtt  = grade(mean_c, rtt_exc_q, rtt_gd_q, rtt_fr_q);
  assign g_jit  = grade(jit_c, RW'(JITTER_EXCELLENT_US), jit_gd_q, jit_fr_q);

  always_comb begin
    q_c = g_loss;
    if (g_rtt > q_c) q_c = g_rtt;
    if (g_jit > q_c) q_c = g_jit;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      quality_o    <= q_c;
      loss_rate_o  <= rate_q;
      lost_count_o <= lost_q;
      mean_rtt_o   <= mean_c;
      min_rtt_o    <= ge2 ? min_q : '0;
      max_rtt_o    <= ge2 ? max_q : '0;
      jitter_o     <= jit_c;
    end
  end

  assign sts_o.div_busy  = div_busy_q;
  assign sts_o.sqrt_busy = sqrt_busy_q;
  assign sts_o.scan_last = (FW'(idx_q) == fill_q - FW'(1));
  assign sts_o.fill_ge2  = ge2;

endmodule

`default_nettype wire

// File: design/link_quality_monitor_unit.sv
// ----------------------------------------------------------------------------
// link_quality_monitor_unit
// Per-event link metrics: loss, window min/max/mean and jitter, graded.
// ----------------------------------------------------------------------------
// The bit-serial divider runs three times per event, or once when the
// window holds fewer than two samples. One event in flight at a time;
// the next event is taken while the previous result waits on the output.
// Reset clears counters, window fill and head, and loads default limits.
`timescale 1ns / 1ps
`default_nettype none

module link_quality_monitor_unit #(
  parameter int unsigned WINDOW              = 64,
  parameter int unsigned JITTER_EXCELLENT_US = 2000
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  lqm_in_if.sink                                in_if,
  lqm_out_if.source                             out_if,
  input  wire logic                             cfg_we_i,
  input  wire logic [lqm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [lqm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  lqm_pkg::lqm_cmd_t cmd;
  lqm_pkg::lqm_sts_t sts;

  lqm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lqm_dp #(
    .WINDOW              (WINDOW),
    .JITTER_EXCELLENT_US (JITTER_EXCELLENT_US)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .mode_i       (in_if.mode),
    .rtt_sample_i (in_if.rtt_sample),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .quality_o    (out_if.quality),
    .loss_rate_o  (out_if.loss_rate),
    .lost_count_o (out_if.lost_count),
    .mean_rtt_o   (out_if.mean_rtt),
    .min_rtt_o    (out_if.min_rtt),
    .max_rtt_o    (out_if.max_rtt),
    .jitter_o     (out_if.jitter)
  );

endmodule

`default_nettype wire

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for link_quality_monitor_unit. Events are fed with
// random gaps into the input channel, and the output is stalled at random
// and once for a long hold-off; one phase has no gaps or stalls. A behavioral
// model of the counters, the RTT window and the grading predicts every result,
// compared field by field. Limits are rewritten between phases while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned WIN      = 64;
  localparam int unsigned JIT_EXC  = 2000;
  localparam int unsigned SETTLE   = 500;
  localparam int unsigned WD_LIMIT = 20000;
  localparam int unsigned HOLD_LEN = 3000;

  localparam logic [1:0] MODE_NOP = 2'd3;
  localparam logic [lqm_pkg::CFG_IDX_W-1:0] CFG_BAD_LO = 4'd8;
  localparam logic [lqm_pkg::CFG_IDX_W-1:0] CFG_BAD_HI = 4'd15;

  typedef struct packed {
    logic [1:0]  mode;
    logic [23:0] rtt;
  } event_t;

  typedef struct packed {
    logic [1:0]  quality;
    logic [13:0] loss_rate;
    logic [31:0] lost_count;
    logic [23:0] mean_rtt;
    logic [23:0] min_rtt;
    logic [23:0] max_rtt;
    logic [23:0] jitter;
  } metrics_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [lqm_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [lqm_pkg::CFG_DATA_W-1:0] cfg_data_i;

  lqm_in_if  ev_bus ();
  lqm_out_if met_bus ();

  link_quality_monitor_unit #(.WINDOW(WIN), .JITTER_EXCELLENT_US(JIT_EXC)) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (ev_bus.sink),
    .out_if     (met_bus.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // model state
  logic [13:0] lim_loss [3];
  logic [23:0] lim_rtt [3];
  logic [23:0] lim_jit [2];
  logic [31:0] sent_cnt, recv_cnt;
  logic [23:0] rtt_win [WIN];
  int unsigned win_fill, win_head;

  event_t   pending_events [$];
  metrics_t expected_metrics [$];
  int unsigned n_events, n_results, n_rtt, n_errors, idle_cycles;
  bit calm;

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v) r = r | (64'd1 << b);
    end
    return r;
  endfunction

  function automatic logic [1:0] grade_of(logic [63:0] v, logic [63:0] l1, logic [63:0] l2,
                                          logic [63:0] l3);
    if (v > l3) return 2'd3;
    if (v > l2) return 2'd2;
    if (v > l1) return 2'd1;
    return 2'd0;
  endfunction

  function automatic metrics_t apply_event(event_t ev);
    metrics_t m;
    logic [63:0] lost, rate, sum, sq, mean, mn, mx, jit, d, x;
    logic [1:0] g;
    lost = 0; rate = 0; mean = 0; mn = 0; mx = 0; jit = 0; sum = 0; sq = 0;
    case (ev.mode)
      lqm_pkg::MODE_SENT: if (sent_cnt != 32'hFFFF_FFFF) sent_cnt++;
      lqm_pkg::MODE_RECV: if (recv_cnt != 32'hFFFF_FFFF) recv_cnt++;
      lqm_pkg::MODE_RTT: begin
        rtt_win[win_head] = ev.rtt;
        win_head = (win_head + 1) % WIN;
        if (win_fill < WIN) win_fill++;
      end
      default: ;
    endcase
    if (sent_cnt != 0) begin
      lost = (sent_cnt > recv_cnt) ? 64'(sent_cnt - recv_cnt) : 64'd0;
      rate = lost * 10000 / sent_cnt;
    end
    if (win_fill >= 2) begin
      mn = 64'hFF_FFFF;
      for (int i = 0; i < win_fill; i++) begin
        x = 64'(rtt_win[i]);
        sum += x;
        if (x < mn) mn = x;
        if (x > mx) mx = x;
      end
      mean = sum / win_fill;
      for (int i = 0; i < win_fill; i++) begin
        x = 64'(rtt_win[i]);
        d = (x > mean) ? x - mean : mean - x;
        sq += d * d;
      end
      jit = floor_sqrt(sq / win_fill);
    end
    m.quality = grade_of(rate, 64'(lim_loss[0]), 64'(lim_loss[1]), 64'(lim_loss[2]));
    g = grade_of(mean, 64'(lim_rtt[0]), 64'(lim_rtt[1]), 64'(lim_rtt[2]));
    if (g > m.quality) m.quality = g;
    g = grade_of(jit, 64'(JIT_EXC), 64'(lim_jit[0]), 64'(lim_jit[1]));
    if (g > m.quality) m.quality = g;
    m.loss_rate = rate[13:0];
    m.lost_count = lost[31:0];
    m.mean_rtt = mean[23:0];
    m.min_rtt = mn[23:0];
    m.max_rtt = mx[23:0];
    m.jitter = jit[23:0];
    return m;
  endfunction

  task automatic write_limit(logic [lqm_pkg::CFG_IDX_W-1:0] idx, logic [23:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      lqm_pkg::CFG_LOSS_EXC: lim_loss[0] = val[13:0];
      lqm_pkg::CFG_LOSS_GD:  lim_loss[1] = val[13:0];
      lqm_pkg::CFG_LOSS_FR:  lim_loss[2] = val[13:0];
      lqm_pkg::CFG_RTT_EXC:  lim_rtt[0] = val;
      lqm_pkg::CFG_RTT_GD:   lim_rtt[1] = val;
      lqm_pkg::CFG_RTT_FR:   lim_rtt[2] = val;
      lqm_pkg::CFG_JIT_GD:   lim_jit[0] = val;
      lqm_pkg::CFG_JIT_FR:   lim_jit[1] = val;
      default: ;
    endcase
  endtask

  task automatic write_all_limits(logic [23:0] l0, logic [23:0] l1, logic [23:0] l2,
                                  logic [23:0] r0, logic [23:0] r1, logic [23:0] r2,
                                  logic [23:0] j1, logic [23:0] j2);
    write_limit(lqm_pkg::CFG_LOSS_EXC, l0);
    write_limit(lqm_pkg::CFG_LOSS_GD, l1);
    write_limit(lqm_pkg::CFG_LOSS_FR, l2);
    write_limit(lqm_pkg::CFG_RTT_EXC, r0);
    write_limit(lqm_pkg::CFG_RTT_GD, r1);
    write_limit(lqm_pkg::CFG_RTT_FR, r2);
    write_limit(lqm_pkg::CFG_JIT_GD, j1);
    write_limit(lqm_pkg::CFG_JIT_FR, j2);
  endtask

  task automatic push_event(logic [1:0] mode, logic [23:0] rtt);
    event_t ev;
    ev.mode = mode;
    ev.rtt = rtt;
    pending_events = {pending_events, ev};
  endtask

  task automatic push_random(int unsigned count);
    int unsigned r;
    logic [23:0] s;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      case ($urandom_range(3))
        0: s = 24'($urandom_range(24'hFF_FFFF));
        1: s = 24'($urandom_range(200));
        default: s = 24'($urandom_range(130000, 1000));
      endcase
      if (r < 35) push_event(lqm_pkg::MODE_SENT, 24'($urandom_range(24'hFF_FFFF)));
      else if (r < 60) push_event(lqm_pkg::MODE_RECV, 24'($urandom_range(24'hFF_FFFF)));
      else if (r < 95) push_event(lqm_pkg::MODE_RTT, s);
      else push_event(MODE_NOP, 24'($urandom_range(24'hFF_FFFF)));
    end
  endtask

  task automatic drain;
    int unsigned guard;
    guard = 0;
    while ((pending_events.size() != 0 || expected_metrics.size() != 0 || ev_bus.valid)
           && guard < 2000000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // event driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      ev_bus.valid <= 1'b0;
    end else if (!ev_bus.valid || ev_bus.ready) begin
      if (pending_events.size() != 0 && (calm || $urandom_range(99) >= 32)) begin
        event_t ev;
        ev = pending_events[0];
        pending_events.delete(0);
        ev_bus.valid <= 1'b1;
        ev_bus.mode <= ev.mode;
        ev_bus.rtt_sample <= ev.rtt;
      end else begin
        ev_bus.valid <= 1'b0;
      end
    end
  end

  // predictor on accepted requests
  always @(posedge clk_i) begin
    if (rst_ni && ev_bus.valid && ev_bus.ready) begin
      event_t ev;
      metrics_t m;
      ev.mode = ev_bus.mode;
      ev.rtt = ev_bus.rtt_sample;
      if (ev.mode == lqm_pkg::MODE_RTT) n_rtt++;
      n_events++;
      m = apply_event(ev);
      expected_metrics = {expected_metrics, m};
    end
  end

  // result receiver with one long hold-off
  int unsigned hold_left;
  bit hold_done;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      met_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      met_bus.ready <= 1'b0;
    end else if (!hold_done && n_results == 120) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      met_bus.ready <= 1'b0;
    end else begin
      met_bus.ready <= calm || ($urandom_range(99) >= 32);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && met_bus.valid && met_bus.ready) begin
      metrics_t got, exp_m;
      got = {met_bus.quality, met_bus.loss_rate, met_bus.lost_count, met_bus.mean_rtt,
             met_bus.min_rtt, met_bus.max_rtt, met_bus.jitter};
      n_results++;
      if (expected_metrics.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("ERROR: unexpected result %p", got);
      end else begin
        exp_m = expected_metrics[0];
        expected_metrics.delete(0);
        if (got !== exp_m) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("ERROR: result %0d mismatch", n_results);
            $display("  expected %p", exp_m);
            $display("  actual   %p", got);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (ev_bus.valid && ev_bus.ready) || (met_bus.valid && met_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding", expected_metrics.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    ev_bus.valid = 1'b0;
    ev_bus.mode = lqm_pkg::MODE_SENT;
    ev_bus.rtt_sample = '0;
    met_bus.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    lim_loss = '{14'd100, 14'd300, 14'd1000};
    lim_rtt = '{24'd20000, 24'd50000, 24'd100000};
    lim_jit = '{24'd5000, 24'd10000};
    sent_cnt = 0;
    recv_cnt = 0;
    win_fill = 0;
    win_head = 0;
    n_events = 0;
    n_results = 0;
    n_rtt = 0;
    n_errors = 0;
    idle_cycles = 0;
    hold_left = 0;
    hold_done = 0;
    calm = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, default limits
    push_event(MODE_NOP, 24'h0);
    push_event(lqm_pkg::MODE_RECV, 24'hFF_FFFF);
    push_event(lqm_pkg::MODE_SENT, 24'h0);
    push_event(lqm_pkg::MODE_RTT, 24'hFF_FFFF);
    push_event(lqm_pkg::MODE_RTT, 24'h0);
    push_event(lqm_pkg::MODE_SENT, 24'h0);
    push_event(lqm_pkg::MODE_SENT, 24'h0);
    push_event(lqm_pkg::MODE_RTT, 24'd30000);
    push_event(lqm_pkg::MODE_RECV, 24'h0);
    push_event(lqm_pkg::MODE_RTT, 24'd60000);
    push_event(MODE_NOP, 24'hFF_FFFF);
    push_event(lqm_pkg::MODE_SENT, 24'h0);
    push_event(lqm_pkg::MODE_RTT, 24'd120000);
    push_event(lqm_pkg::MODE_RECV, 24'h0);
    push_event(lqm_pkg::MODE_RECV, 24'h0);
    push_event(lqm_pkg::MODE_RECV, 24'h0);
    drain();

    // window fills and wraps, no gaps
    calm = 1;
    for (int i = 0; i < 70; i++) push_event(lqm_pkg::MODE_RTT, 24'd20000 + 24'(i * 37));
    drain();
    calm = 0;
    push_random(120);
    drain();

    write_all_limits(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
    push_random(60);
    drain();

    write_all_limits(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
                     24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
    write_limit(CFG_BAD_LO, 24'd0);
    write_limit(CFG_BAD_HI, 24'd0);
    push_random(60);
    drain();

    for (int p = 0; p < 2; p++) begin
      write_all_limits(24'($urandom_range(400)), 24'($urandom_range(1500, 400)),
                       24'($urandom_range(5000, 1500)),
                       24'($urandom_range(40000)), 24'($urandom_range(80000, 40000)),
                       24'($urandom_range(24'hFF_FFFF, 80000)),
                       24'($urandom_range(6000)), 24'($urandom_range(24'hFF_FFFF, 6000)));
      push_random(60);
      drain();
    end

    $display("Covered %0d events (%0d RTT samples), %0d results checked,", n_events, n_rtt,
             n_results);
    $display("over default, zero, maximum and random limit sets; %0d mismatches", n_errors);
    if (n_errors == 0 && expected_metrics.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: link_quality_monitor_unit.f
design/lqm_pkg.sv
design/lqm_if.sv
design/lqm_ctrl.sv
design/lqm_dp.sv
design/link_quality_monitor_unit.sv
test/tb_top.sv
